@@ sv/t2_time_tag_interval_decoder_macros.svh @@
// Assertion macros used by the decoder's checker file.
`ifndef T2_TIME_TAG_INTERVAL_DECODER_MACROS_SVH
`define T2_TIME_TAG_INTERVAL_DECODER_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define TTID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset-qualified.
`define TTID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ttid_pkg.sv @@
// Types and constants for the T2 time-tag interval decoder.
package ttid_pkg;

	localparam int TAG_W   = 28;
	localparam int TIME_W  = 63;
	localparam int IVAL_W  = 31;
	localparam int COUNT_W = 32;

	localparam logic [TIME_W-1:0] WRAP_STEP = 63'd210698240;

	localparam logic [3:0] SPECIAL_CHANNEL   = 4'hF;
	localparam logic [3:0] TOP_LEGAL_CHANNEL = 4'd4;
	localparam logic [3:0] CHAN_START        = 4'd0;
	localparam logic [3:0] CHAN_STOP         = 4'd1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_OVERFLOW = 3'd0,
		KIND_START    = 3'd1,
		KIND_INTERVAL = 3'd2,
		KIND_MARKER   = 3'd3,
		KIND_ILLEGAL  = 3'd4,
		KIND_IGNORED  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		OP_OVERFLOW,
		OP_MARKER,
		OP_START,
		OP_STOP,
		OP_ILLEGAL,
		OP_IGNORED
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] tag;
	} q_entry_t;

endpackage

@@ sv/ttid_front.sv @@
// Front end: decodes the record channel into an operation for the queue.
module ttid_front (
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                record_word,
	input  logic                       q_full,
	output logic                       q_push,
	output ttid_pkg::q_entry_t         q_push_entry
);

	logic [3:0]                  chan;
	logic [ttid_pkg::TAG_W-1:0]  tag;
	ttid_pkg::op_t               op;

	assign chan = record_word[31:28];
	assign tag  = record_word[ttid_pkg::TAG_W-1:0];

	always_comb begin
		if (chan == ttid_pkg::SPECIAL_CHANNEL) begin
			op = (tag[3:0] == 4'd0) ? ttid_pkg::OP_OVERFLOW : ttid_pkg::OP_MARKER;
		end else if (chan > ttid_pkg::TOP_LEGAL_CHANNEL) begin
			op = ttid_pkg::OP_ILLEGAL;
		end else if (chan == ttid_pkg::CHAN_START) begin
			op = ttid_pkg::OP_START;
		end else if (chan == ttid_pkg::CHAN_STOP) begin
			op = ttid_pkg::OP_STOP;
		end else begin
			op = ttid_pkg::OP_IGNORED;
		end
	end

	assign in_ready         = !q_full;
	assign q_push           = in_valid && !q_full;
	assign q_push_entry.op  = op;
	assign q_push_entry.tag = tag;

endmodule

@@ sv/ttid_queue.sv @@
// Short FIFO of decoded operations between the front and back ends.
module ttid_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ttid_pkg::q_entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output ttid_pkg::q_entry_t  head
);

	ttid_pkg::q_entry_t               mem_q [ttid_pkg::QUEUE_DEPTH];
	logic [ttid_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ttid_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ttid_pkg::QCNT_W-1:0]      count_q;

	assign full      = (count_q == ttid_pkg::QCNT_W'(ttid_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/ttid_back.sv @@
// Back end: time unwrap stage, then interval/state update into the result register.
module ttid_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  ttid_pkg::q_entry_t            q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [ttid_pkg::IVAL_W-1:0]   interval,
	output logic [3:0]                    marker_bits,
	output logic [ttid_pkg::TIME_W-1:0]   event_time,
	output logic [ttid_pkg::COUNT_W-1:0]  stops_seen
);

	localparam int TW = ttid_pkg::TIME_W;

	// stage 1: unwrapped time; owns the overflow offset
	logic [TW-1:0]               offset_q;
	logic                        v_s1;
	ttid_pkg::op_t               op_s1;
	logic [ttid_pkg::TAG_W-1:0]  tag_s1;
	logic [TW-1:0]               now_s1;

	// stage 2 state
	logic [TW-1:0]                last_q;
	logic                         armed_q;
	logic [ttid_pkg::COUNT_W-1:0] count_q;
	logic                         out_valid_q;

	logic en1;
	logic en2;
	logic fire2;

	logic [TW:0]                  diff;
	logic [ttid_pkg::IVAL_W-1:0]  ival;
	ttid_pkg::kind_t              r_kind;
	logic [ttid_pkg::IVAL_W-1:0]  r_ival;
	logic [3:0]                   r_marks;
	logic [TW-1:0]                r_time;
	logic [ttid_pkg::COUNT_W-1:0] r_count;
	logic                         set_last;
	logic                         set_armed;
	logic                         clr_armed;

	assign en2   = !out_valid_q || out_ready;
	assign en1   = !v_s1 || en2;
	assign q_pop = q_not_empty && en1;
	assign fire2 = v_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			offset_q <= '0;
		end else begin
			if (en1) begin
				v_s1 <= q_not_empty;
			end
			if (q_pop && q_head.op == ttid_pkg::OP_OVERFLOW) begin
				offset_q <= offset_q + ttid_pkg::WRAP_STEP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1  <= q_head.op;
			tag_s1 <= q_head.tag;
			now_s1 <= offset_q + {{(TW-ttid_pkg::TAG_W){1'b0}}, q_head.tag};
		end
	end

	// negative difference clamps to zero, anything past 31 bits to all ones
	always_comb begin
		diff = {1'b0, now_s1} - {1'b0, last_q};
		if (diff[TW]) begin
			ival = '0;
		end else if (|diff[TW-1:ttid_pkg::IVAL_W]) begin
			ival = '1;
		end else begin
			ival = diff[ttid_pkg::IVAL_W-1:0];
		end
	end

	always_comb begin
		r_kind    = ttid_pkg::KIND_IGNORED;
		r_ival    = '0;
		r_marks   = 4'd0;
		r_time    = '0;
		r_count   = count_q;
		set_last  = 1'b0;
		set_armed = 1'b0;
		clr_armed = 1'b0;
		unique case (op_s1)
			ttid_pkg::OP_OVERFLOW: begin
				r_kind = ttid_pkg::KIND_OVERFLOW;
			end
			ttid_pkg::OP_MARKER: begin
				r_kind   = ttid_pkg::KIND_MARKER;
				r_marks  = tag_s1[3:0];
				r_time   = now_s1;
				set_last = 1'b1;
			end
			ttid_pkg::OP_START: begin
				r_kind    = ttid_pkg::KIND_START;
				r_time    = now_s1;
				set_last  = 1'b1;
				set_armed = 1'b1;
			end
			ttid_pkg::OP_STOP: begin
				if (armed_q) begin
					r_kind    = ttid_pkg::KIND_INTERVAL;
					r_ival    = ival;
					r_time    = now_s1;
					r_count   = count_q + 1'b1;
					set_last  = 1'b1;
					clr_armed = 1'b1;
				end
			end
			ttid_pkg::OP_ILLEGAL: begin
				r_kind = ttid_pkg::KIND_ILLEGAL;
			end
			default: begin
				r_kind = ttid_pkg::KIND_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
			armed_q     <= 1'b0;
			count_q     <= '0;
		end else begin
			if (en2) begin
				out_valid_q <= v_s1;
			end
			if (fire2) begin
				count_q <= r_count;
				if (set_last) begin
					last_q <= now_s1;
				end
				if (set_armed) begin
					armed_q <= 1'b1;
				end else if (clr_armed) begin
					armed_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			kind        <= r_kind;
			interval    <= r_ival;
			marker_bits <= r_marks;
			event_time  <= r_time;
			stops_seen  <= r_count;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/t2_time_tag_interval_decoder.sv @@
// T2 time-tag interval decoder: top level.
// A record accepted into the operation queue passes the back end's stage-1 register, then its result register.
// Throughput: one record per cycle while the 4-entry operation queue is not full; the queue absorbs output stalls.
// The back end's stage-2 register of last time, arm flag and stop count closes the loop.
// Reset (arst_n low) clears offset, last time, arm flag, stop count and the queue.
module t2_time_tag_interval_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   record_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [ttid_pkg::IVAL_W-1:0]   interval,
	output logic [3:0]                    marker_bits,
	output logic [ttid_pkg::TIME_W-1:0]   event_time,
	output logic [ttid_pkg::COUNT_W-1:0]  stops_seen
);

	logic               q_full;
	logic               q_push;
	ttid_pkg::q_entry_t q_push_entry;
	logic               q_pop;
	logic               q_not_empty;
	ttid_pkg::q_entry_t q_head;

	ttid_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.record_word  (record_word),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_push_entry (q_push_entry)
	);

	ttid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	ttid_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.interval    (interval),
		.marker_bits (marker_bits),
		.event_time  (event_time),
		.stops_seen  (stops_seen)
	);

endmodule

@@ sv/ttid_checker.sv @@
// Port-level checker for the decoder, bound to the top level.
`include "t2_time_tag_interval_decoder_macros.svh"

module ttid_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [31:0]                   record_word,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [2:0]                    kind,
	input  logic [ttid_pkg::IVAL_W-1:0]   interval,
	input  logic [3:0]                    marker_bits,
	input  logic [ttid_pkg::TIME_W-1:0]   event_time,
	input  logic [ttid_pkg::COUNT_W-1:0]  stops_seen
);

	// stalled result must hold its kind, time and stop count
	`TTID_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(event_time) && $stable(stops_seen), "result changed while stalled")

	`TTID_ASSERT_NOW(a_ival_only, clk, arst_n, out_valid && kind != ttid_pkg::KIND_INTERVAL, interval == '0, "interval nonzero outside interval item")

	`TTID_ASSERT_NOW(a_marks, clk, arst_n, out_valid && kind == ttid_pkg::KIND_MARKER, marker_bits != 4'd0, "marker item without marker bits")

	`TTID_ASSERT_NOW(a_no_time, clk, arst_n, out_valid && (kind == ttid_pkg::KIND_OVERFLOW || kind == ttid_pkg::KIND_ILLEGAL || kind == ttid_pkg::KIND_IGNORED), event_time == '0 && marker_bits == 4'd0, "time or markers on item without event")

	// a waiting input item must hold
	`TTID_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(record_word), "input item changed while waiting")

endmodule

bind t2_time_tag_interval_decoder ttid_checker u_ttid_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for the T2 time-tag interval decoder.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 900;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		ttid_pkg::kind_t                kind;
		logic [ttid_pkg::IVAL_W-1:0]    ival;
		logic [3:0]                     marks;
		logic [ttid_pkg::TIME_W-1:0]    when;
		logic [ttid_pkg::COUNT_W-1:0]   stops;
	} record_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [31:0]                    record_word;
	logic                           out_valid;
	logic                           out_ready;
	logic [2:0]                     kind;
	logic [ttid_pkg::IVAL_W-1:0]    interval;
	logic [3:0]                     marker_bits;
	logic [ttid_pkg::TIME_W-1:0]    event_time;
	logic [ttid_pkg::COUNT_W-1:0]   stops_seen;

	// decoder state as seen by the testbench
	logic [ttid_pkg::TIME_W-1:0]    ovf_offset;
	logic [ttid_pkg::TIME_W-1:0]    ref_time;
	logic                           start_armed;
	logic [ttid_pkg::COUNT_W-1:0]   stop_total;

	record_result_t       pending_results[$];
	int                   mismatch_count = 0;
	int                   cycle_count = 0;
	bit                   no_idle = 1'b0;
	int                   hold_seq = 0;

	t2_time_tag_interval_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.record_word (record_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.interval    (interval),
		.marker_bits (marker_bits),
		.event_time  (event_time),
		.stops_seen  (stops_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic record_result_t decode_record(input logic [31:0] w);
		record_result_t r;
		logic [ttid_pkg::TAG_W-1:0] tag;
		logic [3:0] ch;
		logic [ttid_pkg::TIME_W-1:0] now;
		logic [ttid_pkg::TIME_W-1:0] diff;
		r = '0;
		r.kind = ttid_pkg::KIND_IGNORED;
		tag = w[ttid_pkg::TAG_W-1:0];
		ch = w[31:28];
		now = ovf_offset + {{(ttid_pkg::TIME_W-ttid_pkg::TAG_W){1'b0}}, tag};
		if (ch == ttid_pkg::SPECIAL_CHANNEL) begin
			r.marks = tag[3:0];
			if (tag[3:0] == 4'h0) begin
				ovf_offset = ovf_offset + ttid_pkg::WRAP_STEP;
				r.kind = ttid_pkg::KIND_OVERFLOW;
			end else begin
				ref_time = now;
				r.when = now;
				r.kind = ttid_pkg::KIND_MARKER;
			end
		end else if (ch > ttid_pkg::TOP_LEGAL_CHANNEL) begin
			r.kind = ttid_pkg::KIND_ILLEGAL;
		end else if (ch == ttid_pkg::CHAN_START) begin
			ref_time = now;
			start_armed = 1'b1;
			r.when = now;
			r.kind = ttid_pkg::KIND_START;
		end else if (ch == ttid_pkg::CHAN_STOP && start_armed) begin
			if (now >= ref_time) begin
				diff = now - ref_time;
				r.ival = (diff > 63'h7FFF_FFFF) ? '1 : diff[ttid_pkg::IVAL_W-1:0];
			end
			stop_total = stop_total + 1'b1;
			ref_time = now;
			start_armed = 1'b0;
			r.when = now;
			r.kind = ttid_pkg::KIND_INTERVAL;
		end
		r.stops = stop_total;
		return r;
	endfunction

	// mostly start/stop traffic with overflows and markers mixed in, plus some noise
	function automatic logic [31:0] random_record();
		int pick;
		logic [ttid_pkg::TAG_W-1:0] tag;
		logic [3:0] ch;
		pick = $urandom_range(99);
		tag = ttid_pkg::TAG_W'($urandom);
		if (pick < 30) begin
			ch = ttid_pkg::CHAN_START;
		end else if (pick < 60) begin
			ch = ttid_pkg::CHAN_STOP;
		end else if (pick < 72) begin
			ch = ttid_pkg::SPECIAL_CHANNEL;
			tag[3:0] = 4'h0;
		end else if (pick < 82) begin
			ch = ttid_pkg::SPECIAL_CHANNEL;
			tag[3:0] = 4'($urandom_range(15, 1));
		end else if (pick < 90) begin
			ch = 4'($urandom_range(4, 2));
		end else if (pick < 95) begin
			ch = 4'($urandom_range(14, 5));
		end else begin
			return $urandom;
		end
		return {ch, tag};
	endfunction

	// called at a rising edge, returns at the edge where the item is taken
	task automatic send_record(input logic [31:0] w);
		while (!no_idle && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		record_word <= w;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(), decode_record(w));
	endtask

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		int hold_left;
		int seen_seq;
		hold_left = 0;
		seen_seq = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 26);
			end
		end
	end

	always @(posedge clk) begin
		record_result_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: kind %0d interval %0d marks %h time %0d stops %0d",
						kind, interval, marker_bits, event_time, stops_seen);
			end else begin
				exp = pending_results.pop_front();
				if (kind !== exp.kind || interval !== exp.ival || marker_bits !== exp.marks ||
				    event_time !== exp.when || stops_seen !== exp.stops) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch exp: kind %0d interval %0d marks %h time %0d stops %0d",
							exp.kind, exp.ival, exp.marks, exp.when, exp.stops);
						$display("         act: kind %0d interval %0d marks %h time %0d stops %0d",
							kind, interval, marker_bits, event_time, stops_seen);
					end
				end
			end
		end
	end

	task automatic test_directed_cases();
		send_record({ttid_pkg::CHAN_STOP, 28'h0000005});        // stop with nothing armed
		send_record({ttid_pkg::CHAN_START, 28'h0000000});
		send_record({ttid_pkg::CHAN_STOP, 28'hFFFFFFF});        // widest in-frame interval
		send_record({ttid_pkg::CHAN_START, 28'hFFFFFFF});
		send_record({ttid_pkg::CHAN_STOP, 28'h0000000});        // stop before reference
		send_record({4'd2, 28'hFFFFFFF});
		send_record({4'd3, 28'hFFFFFFF});
		send_record({4'd4, 28'hFFFFFFF});
		send_record({4'd5, 28'h0000000});
		send_record({4'd14, 28'hFFFFFFF});
		send_record({ttid_pkg::SPECIAL_CHANNEL, 28'hFFFFFFF});  // marker, all marks set
		send_record({ttid_pkg::SPECIAL_CHANNEL, 28'hFFFFFF0});  // overflow, high bits set
		send_record({ttid_pkg::CHAN_START, 28'h0000001});
		send_record({ttid_pkg::SPECIAL_CHANNEL, 28'h0000021});  // marker becomes the reference
		send_record({ttid_pkg::CHAN_STOP, 28'h0000040});
	endtask

	// enough overflows between start and stop to clamp at the top
	task automatic test_long_interval();
		send_record({ttid_pkg::CHAN_START, 28'h0000000});
		repeat (9)
			send_record({ttid_pkg::SPECIAL_CHANNEL,
				ttid_pkg::TAG_W'($urandom) & 28'hFFFFFF0});
		send_record({ttid_pkg::CHAN_STOP, 28'hFFFFFFF});
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		no_idle <= 1'b1;
		hold_seq <= hold_seq + 1;
		repeat (40)
			send_record(random_record());
		no_idle <= 1'b0;
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300)
				no_idle <= 1'b1;
			else if (i == 500)
				no_idle <= 1'b0;
			send_record(random_record());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		record_word = '0;
		ovf_offset = '0;
		ref_time = '0;
		start_armed = 1'b0;
		stop_total = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_long_interval();
		test_backpressure();
		test_random_mix();
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
